@@ hw/rtl/bia_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  // Table geometry.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned LINE_W   = 20;

  // The free-list head holds this value while the free list is empty.
  localparam logic [CNT_W-1:0] FREE_EMPTY = '1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_RANGE    = 2'd2,
    STS_ALR_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // One table entry: allocated flag, free-list link and the stored payload.
  typedef struct packed {
    logic              busy;
    logic [ID_W-1:0]   link;
    logic [TAG_W-1:0]  tag;
    logic [LINE_W-1:0] line;
  } entry_t;

  // Write request from the control logic to the entry memory.
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    entry_t          data;
  } mem_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/bia_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bia_store (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [bia_pkg::ID_W-1:0] rd_addr_i,
  output bia_pkg::entry_t            rd_data_o,
  input  bia_pkg::mem_wr_t           wr_i
);
  import bia_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rd_data_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/bia_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bia_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [bia_pkg::ID_W-1:0]    block_id_i,
  input  wire logic [bia_pkg::TAG_W-1:0]   source_tag_i,
  input  wire logic [bia_pkg::LINE_W-1:0]  line_number_i,
  output logic                             done_o,
  output logic [bia_pkg::ID_W-1:0]         result_id_o,
  output logic [1:0]                       status_o,
  output logic [bia_pkg::CNT_W-1:0]        pending_count_o,
  output logic                             entry_pending_o,
  output logic [bia_pkg::TAG_W-1:0]        entry_tag_o,
  output logic [bia_pkg::LINE_W-1:0]       entry_line_o,
  output logic                             rd_en_o,
  output logic [bia_pkg::ID_W-1:0]         rd_addr_o,
  input  bia_pkg::entry_t                  rd_data_i,
  output bia_pkg::mem_wr_t                 wr_o
);
  import bia_pkg::*;

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [ID_W-1:0]   bid_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LINE_W-1:0] line_q;
  logic [CNT_W-1:0]  free_head_q, free_head_d;
  logic [CNT_W-1:0]  high_water_q, high_water_d;
  logic [CNT_W-1:0]  pending_q, pending_d;
  logic              done_q;
  logic [ID_W-1:0]   rid_q, rid_d;
  status_e           status_q, status_d;
  logic              epend_q, epend_d;
  logic [TAG_W-1:0]  etag_q, etag_d;
  logic [LINE_W-1:0] eline_q, eline_d;
  logic              accept;
  logic              list_empty;
  logic              in_range;

  assign busy_o     = (state_q == S_EXEC);
  assign accept     = start_i && !busy_o;
  assign list_empty = (free_head_q == FREE_EMPTY);
  assign in_range   = ({1'b0, bid_q} < high_water_q);

  // The entry is fetched at the accept edge: the free-list head or the
  // high-water slot for an alloc, the named id otherwise.
  assign rd_en_o = accept;
  always_comb begin
    if (cmd_e'(command_i) == CMD_ALLOC) begin
      rd_addr_o = list_empty ? high_water_q[ID_W-1:0] : free_head_q[ID_W-1:0];
    end else begin
      rd_addr_o = block_id_i;
    end
  end

  // Sequencer: the entry is fetched as the request is accepted, then modified and written back in S_EXEC.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Command execution on the fetched entry.
  always_comb begin
    free_head_d  = free_head_q;
    high_water_d = high_water_q;
    pending_d    = pending_q;
    rid_d        = bid_q;
    status_d     = STS_OK;
    epend_d      = 1'b0;
    etag_d       = '0;
    eline_d      = '0;
    wr_o         = '0;
    wr_o.data    = rd_data_i;

    case (cmd_q)
      CMD_ALLOC: begin
        wr_o.data.busy = 1'b1;
        wr_o.data.tag  = tag_q;
        wr_o.data.line = line_q;
        if (!list_empty) begin
          wr_o.en   = 1'b1;
          wr_o.addr = free_head_q[ID_W-1:0];
          rid_d     = free_head_q[ID_W-1:0];
          pending_d = pending_q + 1'b1;
          // Once every id below the mark is allocated the list is empty.
          if (pending_d >= high_water_q) begin
            free_head_d = FREE_EMPTY;
          end else begin
            free_head_d = {1'b0, rd_data_i.link};
          end
        end else if (high_water_q < CNT_W'(CAPACITY)) begin
          wr_o.en      = 1'b1;
          wr_o.addr    = high_water_q[ID_W-1:0];
          rid_d        = high_water_q[ID_W-1:0];
          high_water_d = high_water_q + 1'b1;
          pending_d    = pending_q + 1'b1;
        end else begin
          rid_d    = '0;
          status_d = STS_FULL;
        end
      end
      CMD_FREE: begin
        if (!in_range) begin
          status_d = STS_RANGE;
        end else if (!rd_data_i.busy) begin
          status_d = STS_ALR_FREE;
        end else begin
          wr_o.en        = 1'b1;
          wr_o.addr      = bid_q;
          wr_o.data.busy = 1'b0;
          wr_o.data.link = free_head_q[ID_W-1:0];
          free_head_d    = {1'b0, bid_q};
          pending_d      = pending_q - 1'b1;
        end
      end
      CMD_FLUSH: begin
        free_head_d  = FREE_EMPTY;
        high_water_d = '0;
        pending_d    = '0;
      end
      default: begin
        if (!in_range) begin
          status_d = STS_RANGE;
        end else begin
          epend_d = rd_data_i.busy;
          etag_d  = rd_data_i.tag;
          eline_d = rd_data_i.line;
        end
      end
    endcase

    if (state_q != S_EXEC) begin
      wr_o.en = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= FREE_EMPTY;
      high_water_q <= '0;
      pending_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= busy_o;
      if (busy_o) begin
        free_head_q  <= free_head_d;
        high_water_q <= high_water_d;
        pending_q    <= pending_d;
      end
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      bid_q  <= block_id_i;
      tag_q  <= source_tag_i;
      line_q <= line_number_i;
    end
    if (busy_o) begin
      rid_q    <= rid_d;
      status_q <= status_d;
      epend_q  <= epend_d;
      etag_q   <= etag_d;
      eline_q  <= eline_d;
    end
  end

  assign done_o          = done_q;
  assign result_id_o     = rid_q;
  assign status_o        = status_q;
  assign pending_count_o = pending_q;
  assign entry_pending_o = epend_q;
  assign entry_tag_o     = etag_q;
  assign entry_line_o    = eline_q;

endmodule

`default_nettype wire

@@ hw/rtl/block_id_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Ports                                          | Handshake
// -----------+------------------------------------------------+---------------------------
// request    | command_i, block_id_i, source_tag_i,           | taken when start_i && !busy_o
//            | line_number_i                                  |
// result     | result_id_o, status_o, pending_count_o,        | valid for one cycle on done_o
//            | entry_pending_o, entry_tag_o, entry_line_o     |
//
// Each request is read, then written back: the entry memory is read at the accept
// edge and the modified entry is written back in the execute cycle that follows,
// from the registered read data of the entry memory. The result appears on done_o
// in the cycle after write-back, and a new request may be accepted in that same cycle.
// Reset empties the free list and clears the high-water mark and pending count;
// the entry memory is not cleared. The receiver cannot stall results.

module block_id_allocator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [bia_pkg::ID_W-1:0]    block_id_i,
  input  wire logic [bia_pkg::TAG_W-1:0]   source_tag_i,
  input  wire logic [bia_pkg::LINE_W-1:0]  line_number_i,
  output logic                             done_o,
  output logic [bia_pkg::ID_W-1:0]         result_id_o,
  output logic [1:0]                       status_o,
  output logic [bia_pkg::CNT_W-1:0]        pending_count_o,
  output logic                             entry_pending_o,
  output logic [bia_pkg::TAG_W-1:0]        entry_tag_o,
  output logic [bia_pkg::LINE_W-1:0]       entry_line_o
);
  import bia_pkg::*;

  logic            rd_en;
  logic [ID_W-1:0] rd_addr;
  entry_t          rd_data;
  mem_wr_t         wr;

  // Command sequencer and allocation state.
  bia_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .block_id_i      (block_id_i),
    .source_tag_i    (source_tag_i),
    .line_number_i   (line_number_i),
    .done_o          (done_o),
    .result_id_o     (result_id_o),
    .status_o        (status_o),
    .pending_count_o (pending_count_o),
    .entry_pending_o (entry_pending_o),
    .entry_tag_o     (entry_tag_o),
    .entry_line_o    (entry_line_o),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_o            (wr)
  );

  // Entry memory: flag, link and payload per id.
  bia_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // An accepted request makes the block busy, with no result strobe, in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request accepted but sequencer not busy next cycle");

  // Every accepted request produces its result strobe on done_o, via the execute state and the done register.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result strobe missing after accepted request");

  // The memory is never written outside the execute cycle.
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> busy_o)
    else $error("entry memory written while idle");

  // A full status means every id is allocated.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STS_FULL)) |-> (pending_count_o == CNT_W'(CAPACITY)))
    else $error("table full reported with free ids left");

endmodule

`default_nettype wire
